// ===== sv/csvdp_pkg.sv =====
// Shared types and constants of the decimal integer field parser.
// Holds register indexes, result codes and the NA string settings struct.
// No dependencies.
package csvdp_pkg;

    localparam int NA_SLOTS     = 2;
    localparam int NA_MAX_CHARS = 8;
    localparam int POS_W        = 4;

    // Digits are taken only while the accumulator stays below this guard.
    localparam logic [63:0] ACC_GUARD = 64'd922337203685477579;

    localparam logic [7:0] CHR_ZERO  = 8'd48;
    localparam logic [7:0] CHR_NINE  = 8'd57;
    localparam logic [7:0] CHR_MINUS = 8'd45;
    localparam logic [7:0] CHR_PLUS  = 8'd43;
    localparam logic [7:0] CHR_SPACE = 8'd32;
    localparam logic [7:0] CHR_TAB   = 8'd9;
    localparam logic [7:0] CHR_CR    = 8'd13;

    localparam logic [2:0] REG_SEP_CHAR       = 3'd0;
    localparam logic [2:0] REG_EOL_CHAR       = 3'd1;
    localparam logic [2:0] REG_NA_COUNT       = 3'd2;
    localparam logic [2:0] REG_NA_TEXT_FIRST  = 3'd3;
    localparam logic [2:0] REG_NA_LEN_FIRST   = 3'd4;
    localparam logic [2:0] REG_NA_TEXT_SECOND = 3'd5;
    localparam logic [2:0] REG_NA_LEN_SECOND  = 3'd6;

    localparam logic [1:0] STATUS_VALUE   = 2'd0;
    localparam logic [1:0] STATUS_NA      = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [1:0] TERM_SEP = 2'd0;
    localparam logic [1:0] TERM_EOL = 2'd1;
    localparam logic [1:0] TERM_EOD = 2'd2;

    typedef struct packed {
        logic [NA_SLOTS-1:0][63:0] text;
        logic [NA_SLOTS-1:0][3:0]  len;
        logic [1:0]                count;
    } na_cfg_t;

    typedef struct packed {
        logic [NA_SLOTS-1:0] mask;
        logic [POS_W-1:0]    pos;
    } na_track_t;

endpackage

// ===== sv/csvdp_na_track.sv =====
// NA string tracker of the decimal integer field parser.
// Advances the per-slot match mask by one byte and tests for a full match.
// Depends on csvdp_pkg.
module csvdp_na_track
    import csvdp_pkg::*;
(
    input  na_cfg_t    na_cfg,
    input  na_track_t  track_cur,
    input  logic [7:0] text_byte,
    output na_track_t  track_next,
    output logic       matched
);

    logic [5:0] bit_ofs;
    logic [1:0] active;

    assign bit_ofs = {track_cur.pos[2:0], 3'b000};
    assign active  = (int'(na_cfg.count) < NA_SLOTS) ? na_cfg.count : 2'(NA_SLOTS);

    // Drop a slot once the byte disagrees or the string is too short.
    always_comb begin
        track_next.mask = track_cur.mask;
        for (int k = 0; k < NA_SLOTS; k++) begin
            if (track_cur.pos >= POS_W'(NA_MAX_CHARS) || na_cfg.len[k] <= track_cur.pos
                || na_cfg.text[k][bit_ofs +: 8] != text_byte) begin
                track_next.mask[k] = 1'b0;
            end
        end
        track_next.pos = (track_cur.pos < POS_W'(NA_MAX_CHARS))
                       ? track_cur.pos + POS_W'(1) : track_cur.pos;
    end

    always_comb begin
        matched = 1'b0;
        for (int k = 0; k < NA_SLOTS; k++) begin
            if (k < int'(active) && track_cur.mask[k] && na_cfg.len[k] >= 4'd1
                && na_cfg.len[k] <= 4'(NA_MAX_CHARS) && na_cfg.len[k] == track_cur.pos) begin
                matched = 1'b1;
            end
        end
    end

endmodule

// ===== sv/csv_decimal_integer_field_parser_core.sv =====
// Top level of the streaming decimal integer field parser.
// The result of a field is registered in the result register when its terminator byte is accepted.
// Throughput: one byte per cycle; the field state and the result register
// are updated in the same cycle, so only a stalled result holds the input.
// Reset (aresetn, synchronous): field state cleared, registers to defaults.
// Depends on csvdp_pkg and csvdp_na_track.
module csv_decimal_integer_field_parser_core
    import csvdp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    // byte requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_end_of_data,
    // result requests
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_int_value,
    output logic [1:0]         m_parse_status,
    output logic [1:0]         m_terminator
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_TRAIL,
        PH_BAD
    } phase_t;

    // Configuration registers
    logic [7:0] sep_char_reg;
    logic [7:0] eol_char_reg;
    na_cfg_t    na_cfg_reg;

    // Field state
    phase_t      phase_reg,   phase_next;
    logic [63:0] acc_reg,     acc_next;
    logic        neg_reg,     neg_next;
    na_track_t   track_reg,   track_next;
    logic        started_reg, started_next;

    // Result register
    logic        m_valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  status_reg;
    logic [1:0]  term_reg;

    logic        accept;
    logic        is_term;
    logic [1:0]  term_code;
    logic        is_digit;
    logic        is_lead_space;
    logic [3:0]  digit;
    logic [63:0] acc_times_ten;
    logic        na_hit;
    na_track_t   track_adv;
    logic [1:0]  status_now;
    logic [63:0] value_now;

    // The result register parts the two sides: take a byte whenever it is free
    // or being drained in this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Terminators win over every phase rule; end of data beats both, separator beats line end.
    always_comb begin
        is_term   = 1'b1;
        term_code = TERM_SEP;
        if (s_end_of_data) begin
            term_code = TERM_EOD;
        end else if (s_text_byte == sep_char_reg) begin
            term_code = TERM_SEP;
        end else if (s_text_byte == eol_char_reg) begin
            term_code = TERM_EOL;
        end else begin
            is_term = 1'b0;
        end
    end

    assign is_digit      = s_text_byte >= CHR_ZERO && s_text_byte <= CHR_NINE;
    assign is_lead_space = s_text_byte == CHR_SPACE
                        || (s_text_byte >= CHR_TAB && s_text_byte <= CHR_CR);
    assign digit         = 4'(s_text_byte - CHR_ZERO);
    // Multiply by ten as two shifts and an add
    assign acc_times_ten = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};

    csvdp_na_track u_na_track (
        .na_cfg     (na_cfg_reg),
        .track_cur  (track_reg),
        .text_byte  (s_text_byte),
        .track_next (track_adv),
        .matched    (na_hit)
    );

    // Result of the field as it stands before this byte
    always_comb begin
        value_now = 64'd0;
        if (!started_reg || na_hit) begin
            status_now = STATUS_NA;
        end else if (phase_reg == PH_DIGITS || phase_reg == PH_TRAIL) begin
            status_now = STATUS_VALUE;
            value_now  = neg_reg ? (64'd0 - acc_reg) : acc_reg;
        end else begin
            status_now = STATUS_INVALID;
        end
    end

    // Field state update for one accepted byte
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        track_next   = track_reg;
        started_next = started_reg;
        if (accept) begin
            if (is_term) begin
                // Close the field: back to a fresh one
                phase_next   = PH_LEAD;
                acc_next     = 64'd0;
                neg_next     = 1'b0;
                track_next   = '{mask: '1, pos: '0};
                started_next = 1'b0;
            end else if (phase_reg == PH_LEAD) begin
                if (!is_lead_space) begin
                    started_next = 1'b1;
                    track_next   = track_adv;
                    if (s_text_byte == CHR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end else if (s_text_byte == CHR_PLUS) begin
                        phase_next = PH_SIGN;
                    end else if (is_digit) begin
                        acc_next   = {60'd0, digit};
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_BAD;
                    end
                end
            end else begin
                track_next = track_adv;
                case (phase_reg)
                    PH_SIGN: begin
                        if (is_digit) begin
                            acc_next   = {60'd0, digit};
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            // At or past the guard a further digit is refused and the field turns invalid
                            if (acc_reg < ACC_GUARD) begin
                                acc_next = acc_times_ten + {60'd0, digit};
                            end else begin
                                phase_next = PH_BAD;
                            end
                        end else if (s_text_byte == CHR_SPACE) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_TRAIL: begin
                        if (s_text_byte != CHR_SPACE) begin
                            phase_next = PH_BAD;
                        end
                    end
                    default: begin
                        phase_next = PH_BAD;
                    end
                endcase
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_char_reg       <= 8'd44;
            eol_char_reg       <= 8'd10;
            na_cfg_reg.count   <= 2'd1;
            na_cfg_reg.text[0] <= 64'd16718;
            na_cfg_reg.len[0]  <= 4'd2;
            na_cfg_reg.text[1] <= 64'd0;
            na_cfg_reg.len[1]  <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SEP_CHAR:       sep_char_reg       <= cfg_wdata[7:0];
                REG_EOL_CHAR:       eol_char_reg       <= cfg_wdata[7:0];
                REG_NA_COUNT:       na_cfg_reg.count   <= cfg_wdata[1:0];
                REG_NA_TEXT_FIRST:  na_cfg_reg.text[0] <= cfg_wdata;
                REG_NA_LEN_FIRST:   na_cfg_reg.len[0]  <= cfg_wdata[3:0];
                REG_NA_TEXT_SECOND: na_cfg_reg.text[1] <= cfg_wdata;
                REG_NA_LEN_SECOND:  na_cfg_reg.len[1]  <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Field state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            acc_reg     <= 64'd0;
            neg_reg     <= 1'b0;
            track_reg   <= '{mask: '1, pos: '0};
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            track_reg   <= track_next;
            started_reg <= started_next;
            if (accept && is_term) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on a closing byte, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept && is_term) begin
            value_reg  <= value_now;
            status_reg <= status_now;
            term_reg   <= term_code;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_int_value    = value_reg;
    assign m_parse_status = status_reg;
    assign m_terminator   = term_reg;

endmodule

// ===== test/tb.sv =====
// Testbench for csv_decimal_integer_field_parser_core: streams text bytes, predicts each
// field result in a scoreboard class and checks every result request against it.
// Depends on csvdp_pkg and the parser RTL; needs nothing else.
module tb;
    import csvdp_pkg::*;

    typedef struct {
        logic signed [63:0] value;
        logic [1:0]         status;
        logic [1:0]         term;
    } field_result_t;

    // Tracks the parser's field state and registers, and holds the results still owed.
    class field_result_board;
        typedef enum logic [2:0] {LEAD_WS, SIGN_SEEN, IN_DIGITS, TRAIL_SP, BAD_FIELD} stage_t;

        logic [7:0]          sep;
        logic [7:0]          eol;
        logic [1:0]          na_cnt;
        logic [63:0]         na_text [NA_SLOTS];
        logic [3:0]          na_len [NA_SLOTS];
        stage_t              stage;
        logic [63:0]         acc;
        bit                  neg;
        bit                  started;
        logic [NA_SLOTS-1:0] mask;
        int unsigned         pos;
        field_result_t       awaited [$];
        int                  errors;

        function new();
            sep        = 8'd44;
            eol        = 8'd10;
            na_cnt     = 2'd1;
            na_text[0] = 64'd16718;
            na_len[0]  = 4'd2;
            na_text[1] = 64'd0;
            na_len[1]  = 4'd1;
            errors     = 0;
            clear_field();
        endfunction

        function void clear_field();
            stage   = LEAD_WS;
            acc     = 64'd0;
            neg     = 1'b0;
            started = 1'b0;
            mask    = '1;
            pos     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                REG_SEP_CHAR:       sep = d[7:0];
                REG_EOL_CHAR:       eol = d[7:0];
                REG_NA_COUNT:       na_cnt = d[1:0];
                REG_NA_TEXT_FIRST:  na_text[0] = d;
                REG_NA_LEN_FIRST:   na_len[0] = d[3:0];
                REG_NA_TEXT_SECOND: na_text[1] = d;
                REG_NA_LEN_SECOND:  na_len[1] = d[3:0];
                default: ;
            endcase
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CHR_ZERO && b <= CHR_NINE;
        endfunction

        // Drop every NA candidate that disagrees with this byte at the current position.
        function void track_na(logic [7:0] b);
            bit keep;
            for (int k = 0; k < NA_SLOTS; k++) begin
                if (pos >= NA_MAX_CHARS || na_len[k] <= pos)
                    keep = 1'b0;
                else
                    keep = (na_text[k][8*pos +: 8] == b);
                if (!keep)
                    mask[k] = 1'b0;
            end
            if (pos < NA_MAX_CHARS)
                pos++;
        endfunction

        function bit na_hit();
            int active;
            bit hit;
            hit    = 1'b0;
            active = (na_cnt < NA_SLOTS) ? int'(na_cnt) : NA_SLOTS;
            for (int k = 0; k < active; k++)
                if (mask[k] && na_len[k] >= 1 && na_len[k] <= NA_MAX_CHARS && na_len[k] == pos)
                    hit = 1'b1;
            return hit;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [63:0] digit;
            digit = {56'd0, 8'(b - CHR_ZERO)};
            if (stage == LEAD_WS) begin
                if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR))
                    return;
                started = 1'b1;
                track_na(b);
                if (b == CHR_MINUS) begin
                    neg   = 1'b1;
                    stage = SIGN_SEEN;
                end else if (b == CHR_PLUS) begin
                    stage = SIGN_SEEN;
                end else if (is_digit(b)) begin
                    acc   = digit;
                    stage = IN_DIGITS;
                end else begin
                    stage = BAD_FIELD;
                end
                return;
            end
            track_na(b);
            case (stage)
                SIGN_SEEN: begin
                    if (is_digit(b)) begin
                        acc   = digit;
                        stage = IN_DIGITS;
                    end else begin
                        stage = BAD_FIELD;
                    end
                end
                IN_DIGITS: begin
                    if (is_digit(b)) begin
                        if (acc < ACC_GUARD)
                            acc = acc * 64'd10 + digit;
                        else
                            stage = BAD_FIELD;
                    end else if (b == CHR_SPACE) begin
                        stage = TRAIL_SP;
                    end else begin
                        stage = BAD_FIELD;
                    end
                end
                TRAIL_SP: begin
                    if (b != CHR_SPACE)
                        stage = BAD_FIELD;
                end
                default: stage = BAD_FIELD;
            endcase
        endfunction

        // Note one accepted byte request; a terminator queues the field's result.
        function void note_byte(logic [7:0] b, logic eod);
            field_result_t r;
            logic [1:0] term;
            if (eod)
                term = TERM_EOD;
            else if (b == sep)
                term = TERM_SEP;
            else if (b == eol)
                term = TERM_EOL;
            else begin
                take_byte(b);
                return;
            end
            r.value = 64'sd0;
            if (!started || na_hit()) begin
                r.status = STATUS_NA;
            end else if (stage == IN_DIGITS || stage == TRAIL_SP) begin
                r.status = STATUS_VALUE;
                r.value  = neg ? (64'd0 - acc) : acc;
            end else begin
                r.status = STATUS_INVALID;
            end
            r.term = term;
            awaited.push_back(r);
            clear_field();
        endfunction

        function void check_result(logic signed [63:0] v, logic [1:0] s, logic [1:0] t);
            field_result_t e;
            if (awaited.size() == 0) begin
                $error("unexpected result: int_value %0d parse_status %0d terminator %0d",
                       v, s, t);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (v !== e.value) begin
                $error("int_value: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (s !== e.status) begin
                $error("parse_status: expected %0d, got %0d", e.status, s);
                errors++;
            end
            if (t !== e.term) begin
                $error("terminator: expected %0d, got %0d", e.term, t);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_text_byte;
    logic               s_end_of_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [63:0] m_int_value;
    logic [1:0]         m_parse_status;
    logic [1:0]         m_terminator;

    bit                 send_calm;
    bit                 take_calm;
    int unsigned        bytes_sent;
    field_result_board  board = new();

    csv_decimal_integer_field_parser_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_data  (s_end_of_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_int_value    (m_int_value),
        .m_parse_status (m_parse_status),
        .m_terminator   (m_terminator)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: stall at random unless the calm stretch is on.
    always @(negedge aclk) begin
        m_ready <= take_calm || ($urandom_range(99) >= 28);
    end

    // Sample result requests at the rising edge, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_int_value, m_parse_status, m_terminator);
    end

    // Offer one byte request; called at a falling edge and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic eod);
        // Idle the sender at random so gaps land on every parse stage.
        while (!send_calm && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_data <= eod;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(b, eod);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            push_byte(txt[i], 1'b0);
    endtask

    task automatic send_digits(input int n);
        repeat (n) push_byte(CHR_ZERO + 8'($urandom_range(9)), 1'b0);
    endtask

    // Close a field with a separator, a line end or end of data (text byte ignored).
    task automatic close_field();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            push_byte(board.sep, 1'b0);
        else if (pick < 85)
            push_byte(board.eol, 1'b0);
        else
            push_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_random_field();
        int kind;
        int n;
        int k;
        logic [7:0] lead [6];
        lead = '{CHR_TAB, 8'd10, 8'd11, 8'd12, CHR_CR, CHR_SPACE};
        kind = $urandom_range(99);
        // Leading whitespace now and then; a byte that is also a terminator splits the field.
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) push_byte(lead[$urandom_range(5)], 1'b0);
        if (kind < 45) begin
            // well-formed number, mostly short, sometimes at the overflow guard
            case ($urandom_range(3))
                0: push_byte(CHR_MINUS, 1'b0);
                1: push_byte(CHR_PLUS, 1'b0);
                default: ;
            endcase
            case ($urandom_range(9))
                0: begin
                    case ($urandom_range(4))
                        0: send_text("9223372036854775789");
                        1: send_text("9223372036854775790");
                        2: send_text("922337203685477578");
                        3: send_text("000000000000000000000123");
                        default: send_text("92233720368547757800");
                    endcase
                end
                1: begin
                    send_text("92233720368547757");
                    send_digits($urandom_range(1, 3));
                end
                2: send_digits($urandom_range(17, 20));
                default: send_digits($urandom_range(1, 6));
            endcase
            repeat ($urandom_range(0, 2)) push_byte(CHR_SPACE, 1'b0);
        end else if (kind < 62) begin
            // an NA string, occasionally spoilt by a trailing space
            k = $urandom_range(1);
            n = int'(board.na_len[k]);
            if (n == 0 || n > NA_MAX_CHARS)
                n = $urandom_range(1, NA_MAX_CHARS);
            for (int i = 0; i < n; i++)
                push_byte(board.na_text[k][8*i +: 8], 1'b0);
            if ($urandom_range(4) == 0)
                push_byte(CHR_SPACE, 1'b0);
        end else if (kind < 70) begin
            // empty field
        end else if (kind < 78) begin
            push_byte($urandom_range(1) ? CHR_MINUS : CHR_PLUS, 1'b0);
            if ($urandom_range(1))
                push_byte(8'($urandom_range(255)), 1'b0);
        end else if (kind < 88) begin
            // digits broken by junk
            send_digits($urandom_range(1, 3));
            case ($urandom_range(3))
                0: push_byte(CHR_TAB, 1'b0);
                1: push_byte(8'd46, 1'b0);
                2: push_byte(CHR_MINUS, 1'b0);
                default: push_byte(8'($urandom_range(255)), 1'b0);
            endcase
            if ($urandom_range(1))
                send_digits($urandom_range(1, 2));
        end else begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 1'b0);
        end
        close_field();
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at)
            send_random_field();
    endtask

    // Hold the sender until every owed result has come, then let the pipe empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        board.set_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_setup(input logic [7:0] sep, input logic [7:0] eol,
                              input logic [1:0] cnt,
                              input logic [63:0] text0, input logic [3:0] len0,
                              input logic [63:0] text1, input logic [3:0] len1);
        write_reg(REG_SEP_CHAR, {56'd0, sep});
        write_reg(REG_EOL_CHAR, {56'd0, eol});
        write_reg(REG_NA_COUNT, {62'd0, cnt});
        write_reg(REG_NA_TEXT_FIRST, text0);
        write_reg(REG_NA_LEN_FIRST, {60'd0, len0});
        write_reg(REG_NA_TEXT_SECOND, text1);
        write_reg(REG_NA_LEN_SECOND, {60'd0, len1});
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SEP_CHAR;
        cfg_wdata     = 64'd0;
        s_valid       = 1'b0;
        s_text_byte   = 8'd0;
        s_end_of_data = 1'b0;
        send_calm     = 1'b0;
        take_calm     = 1'b0;
        bytes_sent    = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed fields at the reset settings: separator ',', line end LF, NA "NA".
        push_byte(8'h00, 1'b1);         // end of data on an empty field
        push_byte(8'hFF, 1'b1);         // and again, straight after
        send_text("NA,");               // exact NA string
        send_text(" -,");               // sign with no digit
        send_text("+0 \n");             // trailing space, closed by line end
        send_text("7\t,");              // tab after digits spoils the field
        send_text("\t-12");
        push_byte(8'h00, 1'b1);         // digits closed by end of data
        push_byte(8'hFF, 1'b0);
        send_text(",NA ,");             // junk byte, then NA with a trailing space
        run_random(250);
        settle();

        // NA strings "null" and "-0": the second one shadows a valid number.
        load_setup(8'd59, 8'd13, 2'd2, 64'h6C6C756E, 4'd4, 64'h302D, 4'd2);
        run_random(135);
        settle();                       // pause mid-phase until all results are in
        run_random(135);
        settle();

        // Separator equal to line end, NA count above the slot count, all-ones text.
        load_setup(8'd0, 8'd0, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h3231, 4'd2);
        run_random(270);
        settle();

        // NA matching off; lengths of zero and above the maximum never match.
        load_setup(8'd255, 8'd9, 2'd0, 64'd16718, 4'd0, {$urandom, $urandom}, 4'd15);
        run_random(270);
        settle();

        // Space as separator; eight-digit NA string that also reads as a number.
        load_setup(8'd32, 8'd10, 2'd2, 64'h4E614E, 4'd3, 64'h3837363534333231, 4'd8);
        run_random(270);
        settle();

        // Back to the defaults with both sides flat out, then random idling again.
        load_setup(8'd44, 8'd10, 2'd1, 64'd16718, 4'd2, 64'd0, 4'd1);
        send_calm = 1'b1;
        take_calm = 1'b1;
        run_random(250);
        send_calm = 1'b0;
        take_calm = 1'b0;
        run_random(150);
        settle();

        repeat (10) @(negedge aclk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (board.awaited.size() != 0)
                $error("%0d results never arrived", board.awaited.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
